/* rtl/fdsu_pkg.sv */
package fdsu_pkg;

    localparam int DATA_DEPTH   = 32;
    localparam int RETURN_DEPTH = 32;
    localparam int WORD_BITS    = 16;

    localparam int DFILL_BITS = $clog2(DATA_DEPTH);
    localparam int RFILL_BITS = $clog2(RETURN_DEPTH);

    // Field widths of the stream beats.
    localparam int OP_BITS      = 3;
    localparam int OPERAND_BITS = 16;
    localparam int READ_BITS    = 16;
    localparam int STATUS_BITS  = 2;
    localparam int COUNT_BITS   = 5;
    localparam int RESULT_BITS  = READ_BITS + STATUS_BITS + 2 * COUNT_BITS;
    localparam int OUT_BITS     = ((RESULT_BITS + 7) / 8) * 8;
    localparam int PAD_BITS     = OUT_BITS - RESULT_BITS;

    // Operation codes.
    localparam logic [OP_BITS-1:0] OP_PUSH      = 3'd0;
    localparam logic [OP_BITS-1:0] OP_POP       = 3'd1;
    localparam logic [OP_BITS-1:0] OP_PICK      = 3'd2;
    localparam logic [OP_BITS-1:0] OP_RPUSH     = 3'd3;
    localparam logic [OP_BITS-1:0] OP_RPOP      = 3'd4;
    localparam logic [OP_BITS-1:0] OP_CLR_DATA  = 3'd5;
    localparam logic [OP_BITS-1:0] OP_CLR_BOTH  = 3'd6;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_OVER  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNDER = 2'd2;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  return_count;
        logic [COUNT_BITS-1:0]  data_count;
        logic [STATUS_BITS-1:0] status;
        logic [READ_BITS-1:0]   read_word;
    } t_result;

endpackage

/* rtl/forth_dual_stack_unit_core.sv */
// Channel   Direction  Payload
// s_axis    in         tuser = op, tdata = operand
// m_axis    out        tdata = read_word, status, data_count, return_count
//
// Push, return push, clear and unused codes have their result registered when the
// beat is taken, and so do pops and picks that underflow. A pop, return pop or
// pick that reads a word also passes through ST_READ, the registered read of the
// stack RAM, and the input is held off during it. Each stack lives in its own registered-read RAM.
// Reset clears both fill counts and the result valid flag; RAM contents and
// the result payload are not cleared. Outside a read cycle an input beat is
// taken while the result register is empty or is being drained in the same cycle.
module forth_dual_stack_unit_core
    import fdsu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [OPERAND_BITS-1:0] s_axis_tdata,   // [15:0] operand
    input  logic [OP_BITS-1:0]      s_axis_tuser,   // [2:0] op
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_BITS-1:0]     m_axis_tdata    // [15:0] read_word, [17:16] status,
                                                    // [22:18] data_count,
                                                    // [27:23] return_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                  r_state;
    logic                  r_out_valid;
    t_result               r_out;
    logic                  r_rd_ret;
    logic [DFILL_BITS-1:0] r_dfill, n_dfill;
    logic [RFILL_BITS-1:0] r_rfill, n_rfill;

    logic                  accept;
    logic [STATUS_BITS-1:0] n_status;
    logic                  rd_data, rd_ret;
    logic                  d_we, rt_we;
    logic [DFILL_BITS-1:0] d_raddr;
    logic [RFILL_BITS-1:0] rt_raddr;
    logic [WORD_BITS-1:0]  push_word;
    logic [WORD_BITS-1:0]  d_rdata, rt_rdata;
    logic                  d_full, rt_full;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_word     = WORD_BITS'(s_axis_tdata);
    assign d_full        = r_dfill == DFILL_BITS'(DATA_DEPTH - 1);
    assign rt_full       = r_rfill == RFILL_BITS'(RETURN_DEPTH - 1);

    always_comb begin
        n_dfill  = r_dfill;
        n_rfill  = r_rfill;
        n_status = ST_OK;
        rd_data  = 1'b0;
        rd_ret   = 1'b0;
        d_we     = 1'b0;
        rt_we    = 1'b0;
        d_raddr  = r_dfill - DFILL_BITS'(1);
        rt_raddr = r_rfill - RFILL_BITS'(1);
        unique case (s_axis_tuser)
            OP_PUSH: begin
                if (d_full) begin
                    n_status = ST_OVER;
                end else begin
                    d_we    = 1'b1;
                    n_dfill = r_dfill + DFILL_BITS'(1);
                end
            end
            OP_POP: begin
                if (r_dfill == '0) begin
                    n_status = ST_UNDER;
                end else begin
                    rd_data = 1'b1;
                    n_dfill = r_dfill - DFILL_BITS'(1);
                end
            end
            OP_PICK: begin
                if (s_axis_tdata >= OPERAND_BITS'(r_dfill)) begin
                    n_status = ST_UNDER;
                end else begin
                    rd_data = 1'b1;
                    d_raddr = r_dfill - DFILL_BITS'(1) - s_axis_tdata[DFILL_BITS-1:0];
                end
            end
            OP_RPUSH: begin
                if (rt_full) begin
                    n_status = ST_OVER;
                end else begin
                    rt_we   = 1'b1;
                    n_rfill = r_rfill + RFILL_BITS'(1);
                end
            end
            OP_RPOP: begin
                if (r_rfill == '0) begin
                    n_status = ST_UNDER;
                end else begin
                    rd_ret  = 1'b1;
                    n_rfill = r_rfill - RFILL_BITS'(1);
                end
            end
            OP_CLR_DATA: begin
                n_dfill = '0;
            end
            OP_CLR_BOTH: begin
                n_dfill = '0;
                n_rfill = '0;
            end
            default: begin
            end
        endcase
    end

    // A read is only issued at an accepted beat and a write only at another
    // accepted beat, so a RAM entry is never read and written in one cycle.
    fdsu_ram #(
        .DEPTH (DATA_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (accept && d_we),
        .i_waddr (r_dfill),
        .i_wdata (push_word),
        .i_re    (accept && rd_data),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    fdsu_ram #(
        .DEPTH (RETURN_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_return_ram (
        .i_clk   (i_clk),
        .i_we    (accept && rt_we),
        .i_waddr (r_rfill),
        .i_wdata (push_word),
        .i_re    (accept && rd_ret),
        .i_raddr (rt_raddr),
        .o_rdata (rt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_dfill     <= '0;
            r_rfill     <= '0;
        end else begin
            if (accept) begin
                r_dfill     <= n_dfill;
                r_rfill     <= n_rfill;
                r_out_valid <= !(rd_data || rd_ret);
                r_state     <= (rd_data || rd_ret) ? ST_READ : ST_IDLE;
            end else if (r_state == ST_READ) begin
                r_out_valid <= 1'b1;
                r_state     <= ST_IDLE;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_ret           <= rd_ret;
            r_out.read_word    <= '0;
            r_out.status       <= n_status;
            r_out.data_count   <= COUNT_BITS'(n_dfill);
            r_out.return_count <= COUNT_BITS'(n_rfill);
        end else if (r_state == ST_READ) begin
            r_out.read_word <= r_rd_ret ? READ_BITS'(rt_rdata) : READ_BITS'(d_rdata);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_BITS{1'b0}}, r_out};

endmodule

/* rtl/fdsu_ram.sv */
module fdsu_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fdsu_checker.sv */
module fdsu_checker
    import fdsu_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tready,
    input logic                i_m_tvalid,
    input logic                i_m_tready,
    input logic [OUT_BITS-1:0] i_m_tdata
);

    t_result res;
    assign res = t_result'(i_m_tdata[RESULT_BITS-1:0]);

    // A waiting result blocks new input beats.
    a_block_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |-> !i_s_tready)
        else $error("input beat taken while a result beat is stalled");

    // A stalled result beat keeps its payload.
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata))
        else $error("result payload changed while stalled");

    // Errors never carry a word.
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && res.status != ST_OK |-> res.read_word == '0)
        else $error("nonzero word with error status");

    // No result beat appears in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_m_tvalid)
        else $error("result beat right after reset");

    // Status stays within its defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (res.status == ST_OK || res.status == ST_OVER ||
                        res.status == ST_UNDER))
        else $error("undefined status code");

endmodule

bind forth_dual_stack_unit_core fdsu_checker u_fdsu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

/* dv/stack_checker.sv */
`timescale 1ns / 100ps

module stack_checker
    import fdsu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [OP_BITS-1:0]      i_in_op,
    input  logic [OPERAND_BITS-1:0] i_in_operand,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [OUT_BITS-1:0]     i_out_data,     // [15:0] read_word, [17:16] status,
                                                    // [22:18] data_count,
                                                    // [27:23] return_count
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_overflows,
    output int                      o_underflows
);

    logic [WORD_BITS-1:0] data_words [DATA_DEPTH];
    logic [WORD_BITS-1:0] return_words [RETURN_DEPTH];
    int data_fill;
    int return_fill;

    t_result expected_results [$];
    int fail_count;
    int checked;
    int overflows;
    int underflows;

    initial begin
        data_fill    = 0;
        return_fill  = 0;
        fail_count   = 0;
        checked      = 0;
        overflows    = 0;
        underflows   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_overflows  = 0;
        o_underflows = 0;
    end

    // Applies one operation to the shadow stacks and returns the result beat it causes.
    function automatic t_result stack_apply(logic [OP_BITS-1:0] op,
                                            logic [OPERAND_BITS-1:0] operand);
        t_result res;
        int depth_n;
        res = '0;
        res.status = ST_OK;
        depth_n = int'(operand);
        case (op)
            OP_PUSH: begin
                if (data_fill >= DATA_DEPTH - 1) begin
                    res.status = ST_OVER;
                end else begin
                    data_words[data_fill] = operand[WORD_BITS-1:0];
                    data_fill++;
                end
            end
            OP_POP: begin
                if (data_fill == 0) begin
                    res.status = ST_UNDER;
                end else begin
                    data_fill--;
                    res.read_word = READ_BITS'(data_words[data_fill]);
                end
            end
            OP_PICK: begin
                if (depth_n >= data_fill) begin
                    res.status = ST_UNDER;
                end else begin
                    res.read_word = READ_BITS'(data_words[data_fill - 1 - depth_n]);
                end
            end
            OP_RPUSH: begin
                if (return_fill >= RETURN_DEPTH - 1) begin
                    res.status = ST_OVER;
                end else begin
                    return_words[return_fill] = operand[WORD_BITS-1:0];
                    return_fill++;
                end
            end
            OP_RPOP: begin
                if (return_fill == 0) begin
                    res.status = ST_UNDER;
                end else begin
                    return_fill--;
                    res.read_word = READ_BITS'(return_words[return_fill]);
                end
            end
            OP_CLR_DATA: begin
                data_fill = 0;
            end
            OP_CLR_BOTH: begin
                data_fill   = 0;
                return_fill = 0;
            end
            default: begin
            end
        endcase
        res.data_count   = COUNT_BITS'(data_fill);
        res.return_count = COUNT_BITS'(return_fill);
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (i_rst_n) begin
            // A result beat can only belong to an input taken at an earlier edge,
            // so the comparison runs before this edge's prediction is queued.
            if (i_out_valid && i_out_ready) begin
                got = t_result'(i_out_data[RESULT_BITS-1:0]);
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: %h", i_out_data);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got.read_word !== want.read_word) begin
                        $error("read_word expected %h got %h", want.read_word, got.read_word);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.data_count !== want.data_count) begin
                        $error("data_count expected %0d got %0d",
                               want.data_count, got.data_count);
                        fail_count++;
                    end
                    if (got.return_count !== want.return_count) begin
                        $error("return_count expected %0d got %0d",
                               want.return_count, got.return_count);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = stack_apply(i_in_op, i_in_operand);
                if (want.status == ST_OVER) overflows++;
                if (want.status == ST_UNDER) underflows++;
                expected_results.push_back(want);
            end
            o_fail_count <= fail_count;
            o_pending    <= expected_results.size();
            o_checked    <= checked;
            o_overflows  <= overflows;
            o_underflows <= underflows;
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import fdsu_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS    = 1400;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT      = 3000;
    localparam int TAIL_CYCLES     = 10;

    typedef enum int {
        MIX_DATA_FILL,
        MIX_DATA_DRAIN,
        MIX_RET_FILL,
        MIX_RET_DRAIN,
        MIX_PICK,
        MIX_BLEND
    } t_mix;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [OPERAND_BITS-1:0] s_axis_tdata = '0;   // [15:0] operand
    logic [OP_BITS-1:0]      s_axis_tuser = '0;   // [2:0] op
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]     m_axis_tdata;        // [15:0] read_word, [17:16] status,
                                                  // [22:18] data_count,
                                                  // [27:23] return_count

    int fail_count;
    int pending;
    int checked;
    int overflows;
    int underflows;

    bit no_gaps = 1'b0;
    bit rx_hold_req = 1'b0;
    int op_sent [8];
    int idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    forth_dual_stack_unit_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    stack_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_op      (s_axis_tuser),
        .i_in_operand (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_overflows  (overflows),
        .o_underflows (underflows)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_beat(logic [OP_BITS-1:0] op, logic [OPERAND_BITS-1:0] operand);
        int gap;
        gap = no_gaps ? 0 : gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= operand;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        op_sent[op]++;
    endtask

    function automatic logic [OP_BITS-1:0] pick_op(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_DATA_FILL: begin
                if (r < 80) return OP_PUSH;
                if (r < 88) return OP_PICK;
                if (r < 94) return OP_POP;
                if (r < 97) return OP_RPUSH;
                return OP_RPOP;
            end
            MIX_DATA_DRAIN: begin
                if (r < 70) return OP_POP;
                if (r < 85) return OP_PICK;
                if (r < 93) return OP_PUSH;
                return OP_RPOP;
            end
            MIX_RET_FILL: begin
                if (r < 80) return OP_RPUSH;
                if (r < 90) return OP_RPOP;
                if (r < 95) return OP_PUSH;
                return OP_PICK;
            end
            MIX_RET_DRAIN: begin
                if (r < 70) return OP_RPOP;
                if (r < 85) return OP_RPUSH;
                if (r < 93) return OP_POP;
                return OP_PICK;
            end
            MIX_PICK: begin
                if (r < 50) return OP_PICK;
                if (r < 80) return OP_PUSH;
                if (r < 95) return OP_POP;
                return OP_RPUSH;
            end
            default: begin
                if (r < 20) return OP_PUSH;
                if (r < 38) return OP_POP;
                if (r < 56) return OP_PICK;
                if (r < 72) return OP_RPUSH;
                if (r < 88) return OP_RPOP;
                if (r < 94) return OP_CLR_DATA;
                return OP_CLR_BOTH;
            end
        endcase
    endfunction

    // Pick distances stay mostly within a live stack; some run past it or far out.
    function automatic logic [OPERAND_BITS-1:0] pick_operand(logic [OP_BITS-1:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (op == OP_PICK) begin
            if (r < 70) return OPERAND_BITS'($urandom_range(0, 7));
            if (r < 90) return OPERAND_BITS'($urandom_range(0, 31));
            return OPERAND_BITS'($urandom);
        end
        if (r < 3) return '0;
        if (r < 6) return '1;
        return OPERAND_BITS'($urandom);
    endfunction

    task automatic run_directed();
        send_beat(OP_POP,      16'h1234);   // pop on an empty data stack
        send_beat(OP_RPOP,     16'hFFFF);   // pop on an empty return stack
        send_beat(OP_PICK,     16'h0000);   // pick on an empty data stack
        send_beat(OP_PUSH,     16'hFFFF);
        send_beat(OP_PUSH,     16'h0000);
        send_beat(OP_PUSH,     16'hA5A5);
        send_beat(OP_PICK,     16'h0000);
        send_beat(OP_PICK,     16'h0002);
        send_beat(OP_PICK,     16'h0003);   // one past the bottom
        send_beat(OP_PICK,     16'hFFFF);
        send_beat(OP_RPUSH,    16'hFFFF);
        send_beat(OP_RPUSH,    16'h1234);
        send_beat(OP_RPUSH,    16'h0000);
        send_beat(OP_PICK,     16'h0002);   // pick two deep while both stacks hold three words
        send_beat(OP_RPOP,     16'h5A5A);
        send_beat(OP_UNUSED,   16'hFFFF);
        send_beat(OP_POP,      16'h0000);
        send_beat(OP_CLR_DATA, 16'hFFFF);
        send_beat(OP_PICK,     16'h0000);
        send_beat(OP_POP,      16'h0000);
        send_beat(OP_PUSH,     16'h8001);
        send_beat(OP_UNUSED,   16'h0000);
        send_beat(OP_CLR_BOTH, 16'h0000);
        send_beat(OP_RPOP,     16'h0000);
        send_beat(OP_POP,      16'h0000);
    endtask

    task automatic run_random();
        int sent;
        int phase;
        int len;
        t_mix mix;
        logic [OP_BITS-1:0] op;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase < 4) mix = t_mix'(phase);
            else mix = t_mix'($urandom_range(0, 5));
            len = (mix == MIX_DATA_FILL || mix == MIX_RET_FILL) ?
                  $urandom_range(45, 60) : $urandom_range(20, 60);
            no_gaps = ($urandom_range(0, 4) == 0);
            // Back-pressure stretch: the sender keeps offering while the sink holds off.
            if (phase == 2 || phase == 9) begin
                no_gaps     = 1'b1;
                rx_hold_req = 1'b1;
            end
            repeat (len) begin
                op = pick_op(mix);
                send_beat(op, pick_operand(op));
                sent++;
            end
            phase++;
        end
        no_gaps = 1'b0;
    endtask

    initial begin : sink
        int run_len;
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 8);
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            stall = gap_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        // Let the checker's pending count take in the last beat's prediction.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d push, %0d pop, %0d pick, %0d return push, %0d return pop,",
                 op_sent[OP_PUSH], op_sent[OP_POP], op_sent[OP_PICK],
                 op_sent[OP_RPUSH], op_sent[OP_RPOP]);
        $display("%0d clears, %0d unused codes; %0d results checked, %0d overflows, %0d %s",
                 op_sent[OP_CLR_DATA] + op_sent[OP_CLR_BOTH], op_sent[OP_UNUSED],
                 checked, overflows, underflows, "underflows.");
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
